[design/cmr_pkg.sv]
// ---------------------------------------------------------------------------
// CAN message reassembler package
// Action codes, result status codes, sequencer states and the error-class
// priority encoder shared by the reassembler.
// ---------------------------------------------------------------------------
package cmr_pkg;

   // Field widths fixed by the transaction format
   localparam int unsigned ACTION_W  = 2;
   localparam int unsigned SOURCE_W  = 8;
   localparam int unsigned ID_W      = 32;
   localparam int unsigned DLC_W     = 4;
   localparam int unsigned DATA_W    = 64;
   localparam int unsigned INDEX_W   = 8;
   localparam int unsigned STATUS_W  = 3;
   localparam int unsigned ECLASS_W  = 4;
   localparam int unsigned MSGLEN_W  = 9;
   localparam int unsigned BYTE_W    = 8;

   // Packed stream widths
   localparam int unsigned REQ_DATA_W = 120;
   localparam int unsigned RSP_DATA_W = 24;

   // Identifier layout
   localparam int unsigned ID_SRC_LSB  = 21;
   localparam int unsigned ID_DST_LSB  = 8;
   localparam int unsigned ID_END_BIT  = 7;
   localparam int unsigned ERR_BITS_W  = 9;

   // Largest frame payload and reported length ceiling
   localparam logic [DLC_W-1:0]    MAX_DLC     = 4'd8;
   localparam logic [MSGLEN_W-1:0] MSGLEN_SAT  = 9'h1FF;

   typedef enum logic [ACTION_W-1:0] {
      ACT_START   = 2'd0,
      ACT_FRAME   = 2'd1,
      ACT_TIMEOUT = 2'd2,
      ACT_READ    = 2'd3
   } action_type;

   localparam logic [STATUS_W-1:0] STATUS_IGNORED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_COMPLETE = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_TIMEOUT  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BADSRC   = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 3'd5;
   localparam logic [STATUS_W-1:0] STATUS_BUSERR   = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_WRITE = 4'b0010,
      ST_READ  = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   // Lowest set error bit wins
   function automatic logic [ECLASS_W-1:0] error_rank(input logic [ERR_BITS_W-1:0] bits);
      logic [ECLASS_W-1:0] rank;
      rank = '0;
      for (int k = ERR_BITS_W - 1; k >= 0; k--) begin
         if (bits[k]) begin
            rank = ECLASS_W'(k);
         end
      end
      return rank;
   endfunction

endpackage

[design/can_message_reassembler_unit.sv]
// ---------------------------------------------------------------------------
// CAN message reassembler
// Collects the payload of extended-ID CAN frames from one source into a
// byte store, reports completion and aborts, and returns stored bytes.
// ---------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------
//  req      | in        | req_tvalid/req_tready | tuser: action, tdata: frame
//  rsp      | out       | rsp_tvalid/rsp_tready | tdata: status, length, byte
//
// Start, timeout, ignored and aborted items: result in the cycle after acceptance.
// An appended frame writes one byte a cycle through the single store write
// port, then gives its result. Reads pass through the read state first.
// The next item is taken the cycle after the result transaction completes.
// Synchronous reset idles the block and clears length and source, not store.
// A stalled result holds the block and its input.
// ---------------------------------------------------------------------------
module can_message_reassembler_unit #(
   parameter int unsigned BUFFER_BYTES = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   // action [1:0]
   input  logic [cmr_pkg::ACTION_W-1:0]     req_tuser,
   // expected_source [7:0], frame_id [39:8], frame_length [43:40],
   // frame_data [107:44], read_index [115:108], zero [119:116]
   input  logic [cmr_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // status [2:0], error_class [6:3], message_length [15:7], read_data [23:16]
   output logic [cmr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready
);
   import cmr_pkg::*;

   localparam int unsigned AW = $clog2(BUFFER_BYTES);
   localparam int unsigned LW = $clog2(BUFFER_BYTES + 1);
   localparam int unsigned MW = (LW > MSGLEN_W) ? LW : MSGLEN_W;

   // Request field unpacking
   logic [SOURCE_W-1:0] in_source;
   logic [ID_W-1:0]     in_id;
   logic [DLC_W-1:0]    in_dlc_raw;
   logic [DLC_W-1:0]    in_dlc;
   logic [DATA_W-1:0]   in_data;
   logic [INDEX_W-1:0]  in_index;
   action_type          in_action;

   assign in_action  = action_type'(req_tuser);
   assign in_source  = req_tdata[7:0];
   assign in_id      = req_tdata[39:8];
   assign in_dlc_raw = req_tdata[43:40];
   assign in_data    = req_tdata[107:44];
   assign in_index   = req_tdata[115:108];
   assign in_dlc     = (in_dlc_raw > MAX_DLC) ? MAX_DLC : in_dlc_raw;

   // Registers
   state_type            state_ff,     state_in;
   logic                 recv_ff,      recv_in;
   logic [SOURCE_W-1:0]  src_ff,       src_in;
   logic [LW-1:0]        len_ff,       len_in;
   logic [DLC_W-1:0]     dlc_ff,       dlc_in;
   logic [DLC_W-1:0]     cnt_ff,       cnt_in;
   logic [DATA_W-1:0]    data_ff,      data_in;
   logic                 rd_ok_ff,     rd_ok_in;
   logic [STATUS_W-1:0]  status_ff,    status_in;
   logic [ECLASS_W-1:0]  eclass_ff,    eclass_in;
   logic [BYTE_W-1:0]    rdata_ff,     rdata_in;
   logic [BYTE_W-1:0]    mem_rd_ff;

   logic [BYTE_W-1:0]    msg_mem [BUFFER_BYTES];

   logic                 req_fire;
   logic                 rsp_fire;
   logic [SOURCE_W-1:0]  id_src;
   logic [SOURCE_W-1:0]  id_dst;
   logic [ERR_BITS_W-1:0] id_errs;
   logic [LW:0]          fill_sum;
   logic [LW-1:0]        wr_pos;
   logic [AW-1:0]        wr_addr;
   logic [AW-1:0]        rd_addr;
   logic                 idx_in_range;
   logic [MW-1:0]        len_wide;
   logic [MSGLEN_W-1:0]  msg_len;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   // Identifier decode and fill check
   assign id_src   = in_id[ID_SRC_LSB +: SOURCE_W];
   assign id_dst   = in_id[ID_DST_LSB +: SOURCE_W];
   assign id_errs  = in_id[ERR_BITS_W-1:0];
   assign fill_sum = (LW+1)'(len_ff) + (LW+1)'(in_dlc);

   // Store addressing
   assign wr_pos       = len_ff + LW'(cnt_ff);
   assign wr_addr      = wr_pos[AW-1:0];
   assign rd_addr      = AW'(in_index);
   assign idx_in_range = (32'(in_index) < 32'(BUFFER_BYTES));

   // Reported length saturates at the field ceiling
   assign len_wide = MW'(len_ff);
   assign msg_len  = (len_wide > MW'(MSGLEN_SAT)) ? MSGLEN_SAT : len_wide[MSGLEN_W-1:0];

   assign rsp_tdata = {rdata_ff, msg_len, eclass_ff, status_ff};

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      recv_in   = recv_ff;
      src_in    = src_ff;
      len_in    = len_ff;
      dlc_in    = dlc_ff;
      cnt_in    = cnt_ff;
      data_in   = data_ff;
      rd_ok_in  = rd_ok_ff;
      status_in = status_ff;
      eclass_in = eclass_ff;
      rdata_in  = rdata_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               status_in = STATUS_IGNORED;
               eclass_in = '0;
               rdata_in  = '0;
               state_in  = ST_RESP;
               unique case (in_action)
                  ACT_START: begin
                     recv_in = 1'b1;
                     src_in  = in_source;
                     len_in  = '0;
                  end
                  ACT_FRAME: begin
                     if (recv_ff) begin
                        if (id_src == '0 && id_dst == '0 && id_errs != '0) begin
                           status_in = STATUS_BUSERR;
                           eclass_in = error_rank(id_errs);
                           recv_in   = 1'b0;
                        end else if (id_src != src_ff) begin
                           status_in = STATUS_BADSRC;
                           recv_in   = 1'b0;
                        end else if (fill_sum > (LW+1)'(BUFFER_BYTES)) begin
                           status_in = STATUS_OVERFLOW;
                           recv_in   = 1'b0;
                        end else begin
                           status_in = in_id[ID_END_BIT] ? STATUS_COMPLETE
                                                         : STATUS_ACCEPTED;
                           recv_in   = !in_id[ID_END_BIT];
                           dlc_in    = in_dlc;
                           cnt_in    = '0;
                           data_in   = in_data;
                           if (in_dlc != '0) begin
                              state_in = ST_WRITE;
                           end
                        end
                     end
                  end
                  ACT_TIMEOUT: begin
                     if (recv_ff) begin
                        status_in = STATUS_TIMEOUT;
                        recv_in   = 1'b0;
                     end
                  end
                  ACT_READ: begin
                     rd_ok_in = idx_in_range;
                     state_in = ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_WRITE: begin
            // one payload byte per cycle
            data_in = data_ff >> BYTE_W;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_in == dlc_ff) begin
               len_in   = len_ff + LW'(dlc_ff);
               state_in = ST_RESP;
            end
         end
         ST_READ: begin
            rdata_in = rd_ok_ff ? mem_rd_ff : '0;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         recv_ff  <= 1'b0;
         src_ff   <= '0;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         recv_ff  <= recv_in;
         src_ff   <= src_in;
         len_ff   <= len_in;
      end
   end

   // Payload and result registers
   always_ff @(posedge clock) begin
      dlc_ff    <= dlc_in;
      cnt_ff    <= cnt_in;
      data_ff   <= data_in;
      rd_ok_ff  <= rd_ok_in;
      status_ff <= status_in;
      eclass_ff <= eclass_in;
      rdata_ff  <= rdata_in;
   end

   // Byte store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE) begin
         msg_mem[wr_addr] <= data_ff[BYTE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && in_action == ACT_READ) begin
         mem_rd_ff <= msg_mem[rd_addr];
      end
   end

   // Checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("input taken while a result is pending");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      32'(len_ff) <= 32'(BUFFER_BYTES))
      else $error("collected length beyond store size");

   a_write_in_store: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (32'(wr_pos) < 32'(BUFFER_BYTES)))
      else $error("store write beyond buffer");

   a_eclass_only_buserr: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && status_ff != STATUS_BUSERR) |-> (eclass_ff == '0))
      else $error("error class set on a non bus error result");

   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |=> (state_ff == ST_IDLE))
      else $error("sequencer not idle after result transaction");

   a_write_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (cnt_ff < dlc_ff && dlc_ff <= MAX_DLC))
      else $error("write counter out of step with frame length");

endmodule

[tb/can_message_reassembler_unit_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// CAN message reassembler testbench
// Drives start, frame, timeout and read transactions into the reassembler.
// A directed opening covers the corner cases, followed by randomised message
// sequences with aborts and noise mixed in. A local predictor tracks the
// byte store and the reception state and checks every result transaction
// field by field, under several sender and receiver idling patterns.
// ---------------------------------------------------------------------------
module can_message_reassembler_unit_tb;
   import cmr_pkg::*;

   localparam int unsigned BUFFER_BYTES = 256;
   localparam int unsigned TARGET_ITEMS = 1150;
   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned SETTLE_CYCLES = 16;

   typedef struct packed {
      action_type           action;
      logic [SOURCE_W-1:0]  expected_source;
      logic [ID_W-1:0]      frame_id;
      logic [DLC_W-1:0]     frame_length;
      logic [DATA_W-1:0]    frame_data;
      logic [INDEX_W-1:0]   read_index;
   } can_request_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [ECLASS_W-1:0]  error_class;
      logic [MSGLEN_W-1:0]  message_length;
      logic [BYTE_W-1:0]    read_data;
   } msg_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic [ACTION_W-1:0]      req_tuser = '0;
   logic [REQ_DATA_W-1:0]    req_tdata = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [RSP_DATA_W-1:0]    rsp_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;

   // Stimulus and expectation stores
   can_request_type   pending_requests[$];
   msg_result_type    expected_results[$];
   can_request_type   next_request;

   int unsigned    error_count = 0;
   int unsigned    handled_count = 0;
   int unsigned    cycle_count = 0;
   int unsigned    phase = 0;
   int unsigned    hold_left = 0;
   logic           hold_done = 1'b0;

   // Predictor state
   logic [BYTE_W-1:0] msg_store[BUFFER_BYTES];
   int unsigned       collected = 0;
   logic [SOURCE_W-1:0] awaited_source = '0;
   logic              receiving = 1'b0;
   int unsigned       written_high = 0;

   can_message_reassembler_unit #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // Clock and run limit
   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Predicts the result of one transaction and advances the reception state
   function automatic msg_result_type reassemble_item(input can_request_type item);
      msg_result_type          res;
      logic [SOURCE_W-1:0]     src;
      logic [SOURCE_W-1:0]     dst;
      logic [ERR_BITS_W-1:0]   errs;
      int unsigned             dlc;
      logic                    found;
      res = '0;
      found = 1'b0;
      dlc = 32'((item.frame_length > MAX_DLC) ? MAX_DLC : item.frame_length);
      case (item.action)
         ACT_START: begin
            receiving = 1'b1;
            awaited_source = item.expected_source;
            collected = 0;
         end
         ACT_FRAME: begin
            if (receiving) begin
               src  = item.frame_id[28:21];
               dst  = item.frame_id[15:8];
               errs = item.frame_id[8:0];
               if (src == '0 && dst == '0 && errs != '0) begin
                  // driver error frame: lowest set bit gives the class
                  res.status = STATUS_BUSERR;
                  for (int k = 0; k < ERR_BITS_W; k++) begin
                     if (errs[k] && !found) begin
                        res.error_class = ECLASS_W'(k);
                        found = 1'b1;
                     end
                  end
                  receiving = 1'b0;
               end else if (src != awaited_source) begin
                  res.status = STATUS_BADSRC;
                  receiving = 1'b0;
               end else if (collected + dlc > BUFFER_BYTES) begin
                  res.status = STATUS_OVERFLOW;
                  receiving = 1'b0;
               end else begin
                  for (int b = 0; b < dlc; b++) begin
                     msg_store[INDEX_W'(collected + 32'(b))] = item.frame_data[8*b +: 8];
                     if (collected + b + 1 > written_high) begin
                        written_high = collected + b + 1;
                     end
                  end
                  collected = collected + dlc;
                  if (item.frame_id[ID_END_BIT]) begin
                     res.status = STATUS_COMPLETE;
                     receiving = 1'b0;
                  end else begin
                     res.status = STATUS_ACCEPTED;
                  end
               end
            end
         end
         ACT_TIMEOUT: begin
            if (receiving) begin
               res.status = STATUS_TIMEOUT;
               receiving = 1'b0;
            end
         end
         default: begin
            if (item.read_index < BUFFER_BYTES) begin
               res.read_data = msg_store[item.read_index];
            end
         end
      endcase
      res.message_length = (collected > 511) ? MSGLEN_SAT : MSGLEN_W'(collected);
      return res;
   endfunction

   function automatic logic [DATA_W-1:0] rand_payload();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [ID_W-1:0] frame_ident(input logic [SOURCE_W-1:0] src,
                                                   input logic [SOURCE_W-1:0] dst,
                                                   input logic end_mark);
      return {3'($urandom), src, 5'($urandom), dst, end_mark, 7'($urandom)};
   endfunction

   function automatic logic sender_pause();
      if (phase == 1) return ($urandom_range(0, 99) < 47);
      if (phase == 3) return ($urandom_range(0, 99) < 16);
      return 1'b0;
   endfunction

   function automatic logic receiver_pause();
      if (phase == 2) return ($urandom_range(0, 99) < 47);
      if (phase == 3) return ($urandom_range(0, 99) < 16);
      return 1'b0;
   endfunction

   task automatic push_item(input action_type act, input logic [SOURCE_W-1:0] src,
                            input logic [ID_W-1:0] id, input logic [DLC_W-1:0] dlc,
                            input logic [DATA_W-1:0] data, input logic [INDEX_W-1:0] idx);
      can_request_type item;
      item.action = act;
      item.expected_source = src;
      item.frame_id = id;
      item.frame_length = dlc;
      item.frame_data = data;
      item.read_index = idx;
      pending_requests.push_back(item);
   endtask

   // Only bytes already written may be read back
   task automatic push_read();
      if (written_high != 0) begin
         push_item(ACT_READ, 8'($urandom), $urandom, 4'($urandom), rand_payload(),
                   8'($urandom_range(0, written_high - 1)));
      end
   endtask

   // One message: start, frames with random content, occasional aborts
   task automatic build_message();
      logic [SOURCE_W-1:0] src;
      logic [7:0]          errbits;
      logic [DLC_W-1:0]    dlc;
      int unsigned         frames;
      int unsigned         roll;
      logic                long_run;
      src = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom);
      push_item(ACT_START, src, $urandom, 4'($urandom), rand_payload(), 8'($urandom));
      roll = $urandom_range(0, 99);
      long_run = (roll < 15);
      if (long_run) begin
         frames = $urandom_range(30, 36);
      end else if (roll < 20) begin
         frames = 0;
      end else begin
         frames = $urandom_range(1, 6);
      end
      for (int f = 0; f < frames; f++) begin
         roll = $urandom_range(0, 99);
         if (long_run && $urandom_range(0, 9) != 0) begin
            dlc = MAX_DLC;
         end else begin
            dlc = 4'($urandom_range(0, 15));
         end
         if (roll < 3) begin
            errbits = ($urandom_range(0, 1) == 0) ? 8'(1 << $urandom_range(0, 7))
                                                   : 8'($urandom_range(1, 255));
            push_item(ACT_FRAME, 8'($urandom),
                      {3'($urandom), 8'h00, 5'($urandom), 8'h00, errbits},
                      dlc, rand_payload(), 8'($urandom));
         end else if (roll < 5) begin
            push_item(ACT_FRAME, 8'($urandom),
                      frame_ident(src ^ 8'($urandom_range(1, 255)), 8'($urandom), 1'($urandom)),
                      dlc, rand_payload(), 8'($urandom));
         end else if (roll < 7) begin
            push_item(ACT_TIMEOUT, 8'($urandom), $urandom, dlc, rand_payload(),
                      8'($urandom));
         end else if (roll < 8) begin
            // re-arm in the middle of a message
            src = 8'($urandom);
            push_item(ACT_START, src, $urandom, dlc, rand_payload(), 8'($urandom));
         end else if (roll < 10) begin
            push_read();
         end else begin
            push_item(ACT_FRAME, 8'($urandom),
                      frame_ident(src, 8'($urandom), f == frames - 1),
                      dlc, rand_payload(), 8'($urandom));
         end
      end
      repeat ($urandom_range(0, 2)) push_read();
      // noise transaction with random fields (a read index stays within the written bytes)
      if ($urandom_range(0, 9) == 0) begin
         roll = $urandom_range(0, 3);
         if (action_type'(roll[ACTION_W-1:0]) == ACT_READ) begin
            push_read();
         end else begin
            push_item(action_type'(roll[ACTION_W-1:0]), 8'($urandom), $urandom,
                      4'($urandom), rand_payload(), 8'($urandom));
         end
      end
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_requests.size() != 0 && !sender_pause()) begin
            next_request = pending_requests.pop_front();
            req_tuser  <= next_request.action;
            req_tdata  <= {4'b0, next_request.read_index, next_request.frame_data,
                           next_request.frame_length, next_request.frame_id,
                           next_request.expected_source};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver, with one long hold-off to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (phase == 0 && !hold_done && handled_count >= 100) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !receiver_pause();
      end
   end

   // Monitor: predict on request transactions, check result transactions
   always @(posedge clock) begin
      can_request_type seen;
      msg_result_type  want;
      msg_result_type  got;
      if (!reset && req_tvalid && req_tready) begin
         seen.action          = action_type'(req_tuser);
         seen.expected_source = req_tdata[7:0];
         seen.frame_id        = req_tdata[39:8];
         seen.frame_length    = req_tdata[43:40];
         seen.frame_data      = req_tdata[107:44];
         seen.read_index      = req_tdata[115:108];
         want = reassemble_item(seen);
         expected_results.push_back(want);
         handled_count <= handled_count + 1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status         = rsp_tdata[2:0];
         got.error_class    = rsp_tdata[6:3];
         got.message_length = rsp_tdata[15:7];
         got.read_data      = rsp_tdata[23:16];
         if (expected_results.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("error_class", 32'(want.error_class), 32'(got.error_class));
            compare_field("message_length", 32'(want.message_length),
                          32'(got.message_length));
            compare_field("read_data", 32'(want.read_data), 32'(got.read_data));
         end
      end
   end

   // Stimulus sequence
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed opening: idle frame and timeout are ignored
      push_item(ACT_FRAME, 8'h00, frame_ident(8'hA5, 8'h01, 1'b0), 4'd8, '1, 8'h00);
      push_item(ACT_TIMEOUT, 8'h00, 32'h0, 4'd0, '0, 8'h00);
      push_item(ACT_START, 8'hA5, 32'h0, 4'd0, '0, 8'h00);
      push_item(ACT_FRAME, 8'h00, 32'hE000_0000 | {3'b000, 8'hA5, 5'h1F, 8'hFF, 1'b0, 7'h7F},
                4'd8, '1, 8'hFF);
      // length code above eight counts as eight; zero length appends nothing
      push_item(ACT_FRAME, 8'h00, {3'b000, 8'hA5, 5'h00, 8'h00, 1'b0, 7'h00}, 4'd15, '0, 8'h00);
      push_item(ACT_FRAME, 8'h00, {3'b000, 8'hA5, 5'h00, 8'h42, 1'b0, 7'h03}, 4'd0, '1, 8'h00);
      push_item(ACT_FRAME, 8'h00, {3'b111, 8'hA5, 5'h00, 8'h42, 1'b1, 7'h00}, 4'd8,
                64'h0123_4567_89AB_CDEF, 8'h00);
      push_item(ACT_FRAME, 8'h00, {3'b000, 8'hA5, 5'h00, 8'h42, 1'b0, 7'h00}, 4'd8, '1, 8'h00);
      // start while receiving re-arms
      push_item(ACT_START, 8'h3C, 32'h0, 4'd0, '0, 8'h00);
      push_item(ACT_START, 8'h00, 32'h0, 4'd0, '0, 8'h00);
      // source zero with nonzero destination is an ordinary frame
      push_item(ACT_FRAME, 8'h00, {3'b000, 8'h00, 5'h00, 8'h12, 1'b0, 7'h7F}, 4'd4,
                64'hFEDC_BA98_7654_3210, 8'h00);
      push_item(ACT_FRAME, 8'h00, 32'h0, 4'd3, 64'h00AA_55CC, 8'h00);
      // end mark on a zero-address frame reads as an error bit
      push_item(ACT_FRAME, 8'h00, 32'h0000_0080, 4'd8, '1, 8'h00);
      push_item(ACT_START, 8'h00, 32'h0, 4'd0, '0, 8'h00);
      push_item(ACT_FRAME, 8'h00, 32'hE01F_0001, 4'd8, '1, 8'h00);
      push_item(ACT_START, 8'h7E, 32'h0, 4'd0, '0, 8'h00);
      push_item(ACT_FRAME, 8'h00, 32'h0000_0006, 4'd2, '1, 8'h00);
      // wrong source aborts
      push_item(ACT_START, 8'hFF, 32'h0, 4'd0, '0, 8'h00);
      push_item(ACT_FRAME, 8'h00, {3'b000, 8'h7F, 5'h00, 8'h01, 1'b0, 7'h00}, 4'd8, '1, 8'h00);
      // timeout while receiving keeps the length
      push_item(ACT_START, 8'hFF, 32'h0, 4'd0, '0, 8'h00);
      push_item(ACT_FRAME, 8'h00, {3'b000, 8'hFF, 5'h00, 8'h01, 1'b0, 7'h00}, 4'd8,
                64'h8877_6655_4433_2211, 8'h00);
      push_item(ACT_TIMEOUT, 8'h00, 32'h0, 4'd0, '0, 8'h00);
      push_item(ACT_READ, 8'h00, 32'h0, 4'd0, '0, 8'd0);
      push_item(ACT_READ, 8'h00, 32'h0, 4'd0, '0, 8'd7);
      push_item(ACT_READ, 8'h00, 32'h0, 4'd0, '0, 8'd23);

      // random messages over the four idling phases
      for (int p = 0; p < 4; p++) begin
         phase = p;
         while (handled_count < (p + 1) * TARGET_ITEMS / 4) begin
            while (pending_requests.size() >= 4) @(negedge clock);
            build_message();
            @(negedge clock);
         end
      end

      // drain, then allow the block's latency for stray results
      while (!(pending_requests.size() == 0 && !req_tvalid && expected_results.size() == 0))
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
